// File: rtl/core/frs_pkg.sv
package frs_pkg;

   localparam int BufBytesDefault   = 4096;
   localparam int MaxRecordsDefault = 256;

   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] FROB_KEY   = 8'h2a;

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_FINISH = 2'd1,
      CMD_READ   = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
      logic       empty_res;
      logic       overflow;
   } rsp_type;

   // byte order used by the sort: xor with key, then unsigned compare
   function automatic logic byte_less(input logic [7:0] a, input logic [7:0] b);
      byte_less = ((a ^ FROB_KEY) < (b ^ FROB_KEY));
   endfunction

endpackage

// File: rtl/core/frs_ram.sv
module frs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: rtl/core/frobnicated_record_sorter_top.sv
// frobnicated record sorter
// Input channel: req (command, data_byte) is taken at a clock edge where
// req_start is high and req_busy is low. Command push stores a byte, a
// space closes a record and repeated spaces are dropped. Command finish
// closes an open record and insertion-sorts the record index table.
// Command read returns one result on rsp (strobe rsp_valid, one cycle).
// Busy: a push, a no-operation or an empty read leaves busy low; a
// read that returns a byte keeps busy high through the order, start and
// byte reads, then the output register, so no new request is taken
// before it is done. Finish runs the index fill, then the outer loop
// with a byte-by-byte record comparison for each insertion step; busy
// stays high throughout.
// An empty read shows its result in the cycle after the transfer, a byte
// read after its order, start and byte reads and the output register, in
// order. The receiver cannot stall, rsp is shown for exactly one cycle.
// Reset clears all counters and flags; no memory clearing is needed, as
// every entry read has been written first.
// Capacity: BUF_BYTES bytes and MAX_RECORDS records; a byte that does not
// fit is dropped and sets the overflow flag reported with every read.
module frobnicated_record_sorter_top
   import frs_pkg::*;
#(
   parameter int BUF_BYTES   = BufBytesDefault,
   parameter int MAX_RECORDS = MaxRecordsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_start,
   output logic    req_busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int BA = $clog2(BUF_BYTES);
   localparam int RA = $clog2(MAX_RECORDS);
   localparam int BC = $clog2(BUF_BYTES + 1);
   localparam int RC = $clog2(MAX_RECORDS + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_RD_ORD, S_RD_START, S_RD_BYTE, S_RD_OUT,
      S_INIT, S_OUTER, S_KEY_RD, S_KEY_WAIT, S_PREV_RD, S_PREV_WAIT,
      S_ST_RD, S_ST_WAIT, S_CMP_RD, S_CMP_A, S_CMP_B, S_SHIFT, S_PLACE
   } state_type;

   state_type state_ff;

   logic [BC-1:0] bytes_ff, open_ff, rpos_ff;
   logic [RC-1:0] recs_ff, rrec_ff, i_ff, j_ff, init_ff;
   logic [BC-1:0] roff_ff;
   logic          lws_ff, ovf_ff, sorted_ff;
   logic [RA-1:0] key_ff, prev_ff;
   logic [BA-1:0] pa_ff, pb_ff;
   logic [7:0]    ca_ff;

   // memory ports
   logic          b_we, s_we, o_we;
   logic [BA-1:0] b_wa, b_ra;
   logic [7:0]    b_wd, b_rd;
   logic [RA-1:0] s_wa, s_ra, o_wa, o_ra;
   logic [BA-1:0] s_wd, s_rd;
   logic [RA-1:0] o_wd, o_rd;

   frs_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_bytes (
      .clock(clock), .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd),
      .rd_addr(b_ra), .rd_data(b_rd));
   frs_ram #(.WIDTH(BA), .DEPTH(MAX_RECORDS)) u_start (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd));
   frs_ram #(.WIDTH(RA), .DEPTH(MAX_RECORDS)) u_order (
      .clock(clock), .wr_en(o_we), .wr_addr(o_wa), .wr_data(o_wd),
      .rd_addr(o_ra), .rd_data(o_rd));

   // closing a record on push of a space or at finish
   logic can_close;
   assign can_close = (bytes_ff < BC'(BUF_BYTES)) && (recs_ff < RC'(MAX_RECORDS));
   logic need_close;
   assign need_close = !lws_ff && (bytes_ff > open_ff);

   logic is_space_a, is_space_b;
   assign is_space_a = (ca_ff == SPACE_CHAR);
   assign is_space_b = (b_rd == SPACE_CHAR);

   assign req_busy = (state_ff != S_IDLE);

   // memory addressing, by state
   always_comb begin
      b_we = 1'b0; b_wa = bytes_ff[BA-1:0]; b_wd = req_data.data_byte;
      s_we = 1'b0; s_wa = recs_ff[RA-1:0];  s_wd = open_ff[BA-1:0];
      o_we = 1'b0; o_wa = init_ff[RA-1:0];  o_wd = init_ff[RA-1:0];
      b_ra = pa_ff; s_ra = key_ff; o_ra = rrec_ff[RA-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_start && req_data.command == CMD_PUSH && !sorted_ff) begin
               if (req_data.data_byte == SPACE_CHAR) begin
                  if (!lws_ff && can_close) begin
                     b_we = 1'b1; b_wd = SPACE_CHAR; s_we = 1'b1;
                  end
               end else if (recs_ff < RC'(MAX_RECORDS) &&
                            BC'(bytes_ff + 1'b1) < BC'(BUF_BYTES)) begin
                  b_we = 1'b1;
               end
            end else if (req_start && req_data.command == CMD_FINISH && !sorted_ff) begin
               if (need_close && can_close) begin
                  b_we = 1'b1; b_wd = SPACE_CHAR; s_we = 1'b1;
               end
            end
         end
         S_INIT:      o_we = 1'b1;
         S_RD_START:  s_ra = o_rd;
         S_RD_BYTE:   b_ra = BA'(s_rd + roff_ff[BA-1:0]);
         S_KEY_RD:    o_ra = i_ff[RA-1:0];
         S_PREV_RD:   o_ra = RA'(j_ff - 1'b1);
         S_ST_RD:     s_ra = key_ff;
         S_ST_WAIT:   s_ra = prev_ff;
         S_CMP_RD:    b_ra = s_rd;
         S_CMP_A:     b_ra = pb_ff;
         S_CMP_B:     b_ra = BA'(pa_ff + 1'b1);
         S_SHIFT: begin
            o_we = 1'b1; o_wa = j_ff[RA-1:0]; o_wd = prev_ff;
         end
         S_PLACE: begin
            o_we = 1'b1; o_wa = j_ff[RA-1:0]; o_wd = key_ff;
         end
         default: ;
      endcase
   end

   // control sequencer with registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bytes_ff <= '0; open_ff <= '0; rpos_ff <= '0;
         recs_ff <= '0; rrec_ff <= '0; roff_ff <= '0;
         lws_ff <= 1'b0; ovf_ff <= 1'b0; sorted_ff <= 1'b0;
         i_ff <= '0; j_ff <= '0; init_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_start) begin
                  case (req_data.command)
                     CMD_PUSH: begin
                        if (!sorted_ff) begin
                           if (req_data.data_byte == SPACE_CHAR) begin
                              if (!lws_ff) begin
                                 if (can_close) begin
                                    bytes_ff <= BC'(bytes_ff + 1'b1);
                                    recs_ff  <= RC'(recs_ff + 1'b1);
                                    open_ff  <= BC'(bytes_ff + 1'b1);
                                 end
                                 lws_ff <= 1'b1;
                              end
                           end else if (recs_ff < RC'(MAX_RECORDS) &&
                                        BC'(bytes_ff + 1'b1) < BC'(BUF_BYTES)) begin
                              bytes_ff <= BC'(bytes_ff + 1'b1);
                              lws_ff   <= 1'b0;
                           end else begin
                              ovf_ff <= 1'b1;
                           end
                        end
                     end
                     CMD_FINISH: begin
                        if (!sorted_ff) begin
                           if (need_close) begin
                              if (can_close) begin
                                 bytes_ff <= BC'(bytes_ff + 1'b1);
                                 recs_ff  <= RC'(recs_ff + 1'b1);
                                 open_ff  <= BC'(bytes_ff + 1'b1);
                              end
                              lws_ff <= 1'b1;
                           end
                           init_ff <= '0;
                           state_ff <= S_INIT;
                        end
                     end
                     CMD_READ: begin
                        if (sorted_ff && rpos_ff < bytes_ff && rrec_ff < recs_ff) begin
                           state_ff <= S_RD_ORD;
                        end else begin
                           rsp_data.out_byte  <= '0;
                           rsp_data.last_byte <= 1'b0;
                           rsp_data.empty_res <= 1'b1;
                           rsp_data.overflow  <= ovf_ff;
                           rsp_valid <= 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_RD_ORD:   state_ff <= S_RD_START;
            S_RD_START: state_ff <= S_RD_BYTE;
            S_RD_BYTE:  state_ff <= S_RD_OUT;
            S_RD_OUT: begin
               if (is_space_b) begin
                  rrec_ff <= RC'(rrec_ff + 1'b1);
                  roff_ff <= '0;
               end else begin
                  roff_ff <= BC'(roff_ff + 1'b1);
               end
               rpos_ff <= BC'(rpos_ff + 1'b1);
               rsp_data.out_byte  <= b_rd;
               rsp_data.last_byte <= (BC'(rpos_ff + 1'b1) == bytes_ff);
               rsp_data.empty_res <= 1'b0;
               rsp_data.overflow  <= ovf_ff;
               rsp_valid <= 1'b1;
               state_ff <= S_IDLE;
            end
            // identity order
            S_INIT: begin
               if (init_ff >= recs_ff) begin
                  i_ff <= RC'(1);
                  state_ff <= S_OUTER;
               end else begin
                  init_ff <= RC'(init_ff + 1'b1);
                  if (RC'(init_ff + 1'b1) >= recs_ff) begin
                     i_ff <= RC'(1);
                     state_ff <= S_OUTER;
                  end
               end
            end
            // insertion sort outer loop
            S_OUTER: begin
               if (i_ff >= recs_ff) begin
                  sorted_ff <= 1'b1;
                  rpos_ff <= '0; rrec_ff <= '0; roff_ff <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  j_ff <= i_ff;
                  state_ff <= S_KEY_RD;
               end
            end
            S_KEY_RD:   state_ff <= S_KEY_WAIT;
            S_KEY_WAIT: begin
               key_ff <= o_rd;
               state_ff <= S_PREV_RD;
            end
            S_PREV_RD: begin
               if (j_ff == '0) begin
                  state_ff <= S_PLACE;
               end else begin
                  state_ff <= S_PREV_WAIT;
               end
            end
            S_PREV_WAIT: begin
               prev_ff <= o_rd;
               state_ff <= S_ST_RD;
            end
            S_ST_RD:   state_ff <= S_ST_WAIT;
            S_ST_WAIT: begin
               pb_ff <= s_rd;
               state_ff <= S_CMP_RD;
            end
            S_CMP_RD: begin
               pa_ff <= s_rd;
               state_ff <= S_CMP_A;
            end
            // byte a arrives; request byte b
            S_CMP_A: begin
               ca_ff <= b_rd;
               state_ff <= S_CMP_B;
            end
            // compare prev (a) against key (b): shift when a > b
            S_CMP_B: begin
               if (is_space_a && is_space_b) begin
                  state_ff <= S_PLACE;
               end else if (is_space_a || byte_less(ca_ff, b_rd)) begin
                  state_ff <= S_PLACE;
               end else if (is_space_b || byte_less(b_rd, ca_ff)) begin
                  state_ff <= S_SHIFT;
               end else begin
                  pa_ff <= BA'(pa_ff + 1'b1);
                  pb_ff <= BA'(pb_ff + 1'b1);
                  state_ff <= S_CMP_A;
               end
            end
            S_SHIFT: begin
               j_ff <= RC'(j_ff - 1'b1);
               state_ff <= S_PREV_RD;
            end
            S_PLACE: begin
               i_ff <= RC'(i_ff + 1'b1);
               state_ff <= S_OUTER;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_no_rsp_when_idle_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_start && req_data.command == CMD_PUSH) |=> !rsp_valid)
      else $error("response after push");
   a_bytes_bounded: assert property (@(posedge clock) disable iff (reset)
      bytes_ff <= BC'(BUF_BYTES))
      else $error("byte count beyond capacity");
   a_read_pos: assert property (@(posedge clock) disable iff (reset)
      rpos_ff <= bytes_ff)
      else $error("read position beyond stored bytes");
   a_sorted_sticky: assert property (@(posedge clock) disable iff (reset)
      sorted_ff |=> sorted_ff)
      else $error("sorted phase left without reset");
`endif

endmodule
